### src/mlpg_pkg.sv
// Shared types and constants of the midpoint line pixel generator.
`timescale 1ns / 1ps

package mlpg_pkg;

  localparam int CoordW  = 6;
  localparam int WalkW   = 7;
  localparam int DecW    = 14;
  localparam int DimW    = 7;
  localparam int ColourW = 24;
  localparam int AddrW   = 32;
  localparam int LinW    = 15;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_INK    = 2'd2,
    REG_BASE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                   x_major;
    logic [WalkW-1:0]       maj_start;
    logic [WalkW-1:0]       min_start;
    logic [CoordW-1:0]      maj_end;
    logic signed [DecW-1:0] d_init;
    logic signed [DecW-1:0] d_lo;
    logic signed [DecW-1:0] d_hi;
  } cmd_t;

  typedef struct packed {
    logic [WalkW-1:0] x;
    logic [WalkW-1:0] y;
    logic             last;
  } point_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [AddrW-1:0]  byte_address;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              in_bounds;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [DimW-1:0]    width;
    logic [DimW-1:0]    height;
    logic [ColourW-1:0] ink_colour;
    logic [AddrW-1:0]   screen_base;
  } cfg_t;

endpackage

### src/mlpg_front.sv
// Front end: accepts endpoint pairs, sets up the line and queues the commands.
`timescale 1ns / 1ps

module mlpg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [mlpg_pkg::CoordW-1:0]   x_start,
  input  logic [mlpg_pkg::CoordW-1:0]   y_start,
  input  logic [mlpg_pkg::CoordW-1:0]   x_end,
  input  logic [mlpg_pkg::CoordW-1:0]   y_end,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output mlpg_pkg::cmd_t                cmd
);

  logic signed [mlpg_pkg::WalkW-1:0] dx;
  logic signed [mlpg_pkg::WalkW-1:0] dy;
  logic signed [mlpg_pkg::WalkW-1:0] d_maj;
  logic signed [mlpg_pkg::WalkW-1:0] d_min;
  logic signed [mlpg_pkg::WalkW-1:0] half_maj;
  mlpg_pkg::cmd_t                    cmd_in;
  mlpg_pkg::cmd_t                    queue [2];
  logic                              wr_ptr;
  logic                              rd_ptr;
  logic [1:0]                        count;
  logic                              do_push;
  logic                              do_pop;

  assign dx    = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
  assign dy    = $signed({1'b0, y_end}) - $signed({1'b0, y_start});

  always_comb begin
    cmd_in.x_major = (dy <= dx);
    if (cmd_in.x_major) begin
      d_maj            = dx;
      d_min            = dy;
      cmd_in.maj_start = {1'b0, x_start};
      cmd_in.min_start = {1'b0, y_start};
      cmd_in.maj_end   = x_end;
    end else begin
      d_maj            = dy;
      d_min            = dx;
      cmd_in.maj_start = {1'b0, y_start};
      cmd_in.min_start = {1'b0, x_start};
      cmd_in.maj_end   = y_end;
    end
    // halve toward zero
    half_maj      = (d_maj + $signed({{(mlpg_pkg::WalkW-1){1'b0}}, d_maj[mlpg_pkg::WalkW-1]}))
                    >>> 1;
    cmd_in.d_init = mlpg_pkg::DecW'(d_min) - mlpg_pkg::DecW'(half_maj);
    cmd_in.d_lo   = mlpg_pkg::DecW'(d_min);
    cmd_in.d_hi   = mlpg_pkg::DecW'(d_min) - mlpg_pkg::DecW'(d_maj);
  end

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) queue[wr_ptr] <= cmd_in;
  end

endmodule

### src/mlpg_stepper.sv
// Back end: walks one queued line a point per cycle while pt_ready is high.
`timescale 1ns / 1ps

module mlpg_stepper (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  mlpg_pkg::cmd_t  cmd,
  output logic            pt_valid,
  input  logic            pt_ready,
  output mlpg_pkg::point_t pt
);

  logic                              busy;
  logic                              x_major;
  logic [mlpg_pkg::WalkW-1:0]        maj;
  logic [mlpg_pkg::WalkW-1:0]        min_c;
  logic [mlpg_pkg::CoordW-1:0]       maj_end;
  logic signed [mlpg_pkg::DecW-1:0]  d;
  logic signed [mlpg_pkg::DecW-1:0]  d_lo;
  logic signed [mlpg_pkg::DecW-1:0]  d_hi;
  logic                              at_end;
  logic                              step;

  assign cmd_ready = !busy;
  assign pt_valid  = busy;
  assign at_end    = (maj >= {1'b0, maj_end});
  assign step      = busy && pt_ready;

  assign pt.x    = x_major ? maj : min_c;
  assign pt.y    = x_major ? min_c : maj;
  assign pt.last = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      busy <= cmd_valid;
    end else if (step && at_end) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      x_major <= cmd.x_major;
      maj     <= cmd.maj_start;
      min_c   <= cmd.min_start;
      maj_end <= cmd.maj_end;
      d       <= cmd.d_init;
      d_lo    <= cmd.d_lo;
      d_hi    <= cmd.d_hi;
    end else if (step && !at_end) begin
      maj <= maj + 1'b1;
      if (d < 0) begin
        d <= d + d_lo;
      end else begin
        d     <= d + d_hi;
        min_c <= min_c + 1'b1;
      end
    end
  end

endmodule

### src/mlpg_pixel.sv
// Back end: clips points, forms frame buffer addresses and queues the results.
`timescale 1ns / 1ps

module mlpg_pixel (
  input  logic                 clk,
  input  logic                 rst,
  input  mlpg_pkg::cfg_t       cfg,
  input  logic                 pt_valid,
  output logic                 pt_ready,
  input  mlpg_pkg::point_t     pt,
  output logic                 empty,
  input  logic                 pop,
  output mlpg_pkg::result_t    res
);

  logic [mlpg_pkg::DecW-1:0] prod;
  logic                      s1_valid;
  logic                      s1_ready;
  mlpg_pkg::point_t          s1_pt;
  logic                      s1_vis;
  logic [mlpg_pkg::LinW-1:0] s1_lin;
  logic                      s2_valid;
  logic                      s2_ready;
  mlpg_pkg::result_t         s2_res;
  mlpg_pkg::result_t         queue [2];
  logic                      wr_ptr;
  logic                      rd_ptr;
  logic [1:0]                count;
  logic                      q_push;
  logic                      q_pop;

  assign prod     = mlpg_pkg::DecW'(cfg.width) * mlpg_pkg::DecW'(pt.y);
  assign q_push   = s2_valid && (count != 2'd2);
  assign q_pop    = pop && !empty;
  assign s2_ready = !s2_valid || (count != 2'd2);
  assign s1_ready = !s1_valid || s2_ready;
  assign pt_ready = s1_ready;
  assign empty    = (count == 2'd0);
  assign res      = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= pt_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_pt  <= pt;
      s1_vis <= (pt.x < cfg.width) && (pt.y < cfg.height);
      s1_lin <= mlpg_pkg::LinW'(prod) + mlpg_pkg::LinW'(pt.x);
    end
    if (s2_ready) begin
      s2_res.pixel_x   <= s1_pt.x[mlpg_pkg::CoordW-1:0];
      s2_res.pixel_y   <= s1_pt.y[mlpg_pkg::CoordW-1:0];
      s2_res.last      <= s1_pt.last;
      s2_res.in_bounds <= s1_vis;
      if (s1_vis) begin
        s2_res.byte_address <= cfg.screen_base + mlpg_pkg::AddrW'({s1_lin, 1'b0})
                               + mlpg_pkg::AddrW'(s1_lin);
        s2_res.red          <= cfg.ink_colour[7:0];
        s2_res.green        <= cfg.ink_colour[15:8];
        s2_res.blue         <= cfg.ink_colour[23:16];
      end else begin
        s2_res.byte_address <= '0;
        s2_res.red          <= '0;
        s2_res.green        <= '0;
        s2_res.blue         <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      if (q_push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !q_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) queue[wr_ptr] <= s2_res;
  end

endmodule

### src/midpoint_line_pixel_generator.sv
// Top level of the midpoint line pixel generator.
`timescale 1ns / 1ps

// Each pushed endpoint pair whose end coordinates are no smaller than its start ones yields
// one result per point of its midpoint line, start point first, last set on the final one;
// a line of n points (n at most 64) is walked by the stepper a single point per cycle
// while the pixel stage accepts points, and the stepper takes up the next queued line only
// once it is through with the current one. Up to two lines wait ahead of the stepper and
// two results wait at the output, so push and pop stall independently. Configuration
// takes effect on points stepped after the write.

module midpoint_line_pixel_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [mlpg_pkg::CoordW-1:0]     x_start,
  input  logic [mlpg_pkg::CoordW-1:0]     y_start,
  input  logic [mlpg_pkg::CoordW-1:0]     x_end,
  input  logic [mlpg_pkg::CoordW-1:0]     y_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [mlpg_pkg::CoordW-1:0]     pixel_x,
  output logic [mlpg_pkg::CoordW-1:0]     pixel_y,
  output logic [mlpg_pkg::AddrW-1:0]      byte_address,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic                            in_bounds,
  output logic                            last,
  input  logic                            cfg_we,
  input  logic [mlpg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mlpg_pkg::CfgDataW-1:0]   cfg_data
);

  mlpg_pkg::cfg_t    cfg;
  mlpg_pkg::cmd_t    cmd;
  logic              cmd_valid;
  logic              cmd_ready;
  mlpg_pkg::point_t  pt;
  logic              pt_valid;
  logic              pt_ready;
  mlpg_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (mlpg_pkg::cfg_reg_t'(cfg_index))
        mlpg_pkg::REG_WIDTH:  cfg.width       <= cfg_data[mlpg_pkg::DimW-1:0];
        mlpg_pkg::REG_HEIGHT: cfg.height      <= cfg_data[mlpg_pkg::DimW-1:0];
        mlpg_pkg::REG_INK:    cfg.ink_colour  <= cfg_data[mlpg_pkg::ColourW-1:0];
        mlpg_pkg::REG_BASE:   cfg.screen_base <= cfg_data[mlpg_pkg::AddrW-1:0];
        default:              cfg             <= cfg;
      endcase
    end
  end

  mlpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mlpg_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt)
  );

  mlpg_pixel u_pixel (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .pt       (pt),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign pixel_x      = res.pixel_x;
  assign pixel_y      = res.pixel_y;
  assign byte_address = res.byte_address;
  assign red          = res.red;
  assign green        = res.green;
  assign blue         = res.blue;
  assign in_bounds    = res.in_bounds;
  assign last         = res.last;

  a_clipped_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !in_bounds) |->
      (byte_address == '0 && red == '0 && green == '0 && blue == '0))
    else $error("clipped point carries address or colour");

  a_line_continues: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && pt_ready && !pt.last) |=> pt_valid)
    else $error("stepper dropped a line before its final point");

  a_line_closes: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && pt_ready && pt.last) |=> !pt_valid)
    else $error("stepper kept running past the final point");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> pt_valid)
    else $error("queued line not taken up by the stepper");

endmodule
